// ===== rtl/bl3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bl3_pkg: shared types and constants of the 3D line generator
// Command codes, driving axis encoding and fixed channel field widths.
// ----------------------------------------------------------------------------
package bl3_pkg;

  localparam int OUT_COORD_BITS = 16;
  localparam int COUNT_BITS     = 17;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

endpackage

// ===== rtl/bl3_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bl3_cmd_if: command channel of the 3D line generator
// Valid/ready channel carrying a start or step command and the two endpoints.
// ----------------------------------------------------------------------------
interface bl3_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 command;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   src_x;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   src_y;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   src_z;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   dst_x;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   dst_y;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   dst_z;

  modport source (
    output valid, command, src_x, src_y, src_z, dst_x, dst_y, dst_z,
    input  ready
  );

  modport sink (
    input  valid, command, src_x, src_y, src_z, dst_x, dst_y, dst_z,
    output ready
  );
endinterface

// ===== rtl/bl3_point_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bl3_point_if: point channel of the 3D line generator
// Valid/ready channel carrying one line point, its count and the last flag.
// ----------------------------------------------------------------------------
interface bl3_point_if;
  logic                                 valid;
  logic                                 ready;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   point_x;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   point_y;
  logic [bl3_pkg::OUT_COORD_BITS-1:0]   point_z;
  logic [bl3_pkg::COUNT_BITS-1:0]       point_count;
  logic                                 last;

  modport source (
    output valid, point_x, point_y, point_z, point_count, last,
    input  ready
  );

  modport sink (
    input  valid, point_x, point_y, point_z, point_count, last,
    output ready
  );
endinterface

// ===== rtl/bresenham_line_3d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_3d: 3D Bresenham line generator
// Start loads a line and returns its source point; each step returns the
// next point with a running count and a last flag, or repeats the end point.
// ----------------------------------------------------------------------------
//  channel  direction  transfer carries
//  cmd      sink       command, src_x/y/z, dst_x/y/z
//  point    source     point_x/y/z, point_count, last
//
//  One result per command; one command per cycle sustained while point is ready.
//  A command reaches the point output through two register stages (setup
//  register, then the point/state register, which is also the output
//  register).
//  The loop through the error terms and current point closes through the point/state register alone.
//  Reset: synchronous; clears the valid of both stages, state reads as a finished line
//  at (0,0,0) with count 1. A stalled point holds its stage and backs up
//  cmd through the setup register.
// ----------------------------------------------------------------------------
module bresenham_line_3d #(
  parameter int COORD_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  bl3_cmd_if.sink       cmd,
  bl3_point_if.source   point
);

  localparam int ERR_BITS = COORD_BITS + 2;
  localparam int OUT_BITS = bl3_pkg::OUT_COORD_BITS;
  localparam int CNT_BITS = bl3_pkg::COUNT_BITS;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [CNT_BITS-1:0]        count_t;

  logic   cmd_xfer;
  logic   out_free;
  logic   adv;

  coord_t su_dx, su_dy, su_dz;
  logic [2:0] su_signs;

  logic   s1_valid;
  logic   s1_command;
  coord_t s1_src_x, s1_src_y, s1_src_z;
  coord_t s1_dst_x, s1_dst_y, s1_dst_z;
  coord_t s1_dx, s1_dy, s1_dz;
  logic [2:0] s1_signs;

  logic   pvalid;
  coord_t cur_x, cur_y, cur_z;
  coord_t end_drive;
  coord_t d_drive, d_first, d_second;
  err_t   err_first, err_second;
  bl3_pkg::axis_t drive;
  logic [2:0] signs;
  count_t count;
  logic   done;

  coord_t cur_x_next, cur_y_next, cur_z_next;
  coord_t end_drive_next;
  coord_t d_drive_next, d_first_next, d_second_next;
  err_t   err_first_next, err_second_next;
  bl3_pkg::axis_t drive_next;
  logic [2:0] signs_next;
  count_t count_next;
  logic   done_next;

  logic   ge_x, ge_y;
  logic   ef_ge, es_ge;
  logic   mv_x, mv_y, mv_z;
  coord_t drive_pos;

  assign out_free  = !pvalid || point.ready;
  assign adv       = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;
  assign cmd_xfer  = cmd.valid && cmd.ready;

  bl3_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .src_x   (COORD_BITS'(cmd.src_x)),
    .src_y   (COORD_BITS'(cmd.src_y)),
    .src_z   (COORD_BITS'(cmd.src_z)),
    .dst_x   (COORD_BITS'(cmd.dst_x)),
    .dst_y   (COORD_BITS'(cmd.dst_y)),
    .dst_z   (COORD_BITS'(cmd.dst_z)),
    .delta_x (su_dx),
    .delta_y (su_dy),
    .delta_z (su_dz),
    .signs   (su_signs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_xfer) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      s1_command <= cmd.command;
      s1_src_x   <= COORD_BITS'(cmd.src_x);
      s1_src_y   <= COORD_BITS'(cmd.src_y);
      s1_src_z   <= COORD_BITS'(cmd.src_z);
      s1_dst_x   <= COORD_BITS'(cmd.dst_x);
      s1_dst_y   <= COORD_BITS'(cmd.dst_y);
      s1_dst_z   <= COORD_BITS'(cmd.dst_z);
      s1_dx      <= su_dx;
      s1_dy      <= su_dy;
      s1_dz      <= su_dz;
      s1_signs   <= su_signs;
    end
  end

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    cur_z_next      = cur_z;
    end_drive_next  = end_drive;
    d_drive_next    = d_drive;
    d_first_next    = d_first;
    d_second_next   = d_second;
    err_first_next  = err_first;
    err_second_next = err_second;
    drive_next      = drive;
    signs_next      = signs;
    count_next      = count;
    done_next       = done;

    ge_x  = (s1_dx >= s1_dy) && (s1_dx > s1_dz);
    ge_y  = (s1_dy >= s1_dx) && (s1_dy > s1_dz);
    ef_ge = !err_first[ERR_BITS-1];
    es_ge = !err_second[ERR_BITS-1];
    mv_x  = (drive == bl3_pkg::AXIS_X) || ef_ge;
    mv_y  = (drive == bl3_pkg::AXIS_Y) ||
            ((drive == bl3_pkg::AXIS_X) && ef_ge) ||
            ((drive == bl3_pkg::AXIS_Z) && es_ge);
    mv_z  = (drive == bl3_pkg::AXIS_Z) || es_ge;
    drive_pos = cur_z;

    case (s1_command)
      bl3_pkg::CMD_START: begin
        cur_x_next = s1_src_x;
        cur_y_next = s1_src_y;
        cur_z_next = s1_src_z;
        signs_next = s1_signs;
        if (ge_x) begin
          drive_next     = bl3_pkg::AXIS_X;
          end_drive_next = s1_dst_x;
          d_drive_next   = s1_dx;
          d_first_next   = s1_dy;
          d_second_next  = s1_dz;
        end else if (ge_y) begin
          drive_next     = bl3_pkg::AXIS_Y;
          end_drive_next = s1_dst_y;
          d_drive_next   = s1_dy;
          d_first_next   = s1_dx;
          d_second_next  = s1_dz;
        end else begin
          drive_next     = bl3_pkg::AXIS_Z;
          end_drive_next = s1_dst_z;
          d_drive_next   = s1_dz;
          d_first_next   = s1_dx;
          d_second_next  = s1_dy;
        end
        err_first_next  = ERR_BITS'({d_first_next, 1'b0}) - ERR_BITS'(d_drive_next);
        err_second_next = ERR_BITS'({d_second_next, 1'b0}) - ERR_BITS'(d_drive_next);
        count_next      = CNT_BITS'(1);
        done_next       = (d_drive_next == '0);
      end
      bl3_pkg::CMD_STEP: begin
        if (!done) begin
          if (mv_x) begin
            cur_x_next = signs[0] ? cur_x + COORD_BITS'(1) : cur_x - COORD_BITS'(1);
          end
          if (mv_y) begin
            cur_y_next = signs[1] ? cur_y + COORD_BITS'(1) : cur_y - COORD_BITS'(1);
          end
          if (mv_z) begin
            cur_z_next = signs[2] ? cur_z + COORD_BITS'(1) : cur_z - COORD_BITS'(1);
          end
          err_first_next  = err_first + ERR_BITS'({d_first, 1'b0})
                          - (ef_ge ? ERR_BITS'({d_drive, 1'b0}) : '0);
          err_second_next = err_second + ERR_BITS'({d_second, 1'b0})
                          - (es_ge ? ERR_BITS'({d_drive, 1'b0}) : '0);
          if (count != '1) begin
            count_next = count + CNT_BITS'(1);
          end
          case (drive)
            bl3_pkg::AXIS_X: drive_pos = cur_x_next;
            bl3_pkg::AXIS_Y: drive_pos = cur_y_next;
            bl3_pkg::AXIS_Z: drive_pos = cur_z_next;
            default:         drive_pos = cur_z_next;
          endcase
          done_next = (drive_pos == end_drive);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid     <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      cur_z      <= '0;
      end_drive  <= '0;
      d_drive    <= '0;
      d_first    <= '0;
      d_second   <= '0;
      err_first  <= '0;
      err_second <= '0;
      drive      <= bl3_pkg::AXIS_X;
      signs      <= '0;
      count      <= CNT_BITS'(1);
      done       <= 1'b1;
    end else begin
      if (adv) begin
        pvalid     <= 1'b1;
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        cur_z      <= cur_z_next;
        end_drive  <= end_drive_next;
        d_drive    <= d_drive_next;
        d_first    <= d_first_next;
        d_second   <= d_second_next;
        err_first  <= err_first_next;
        err_second <= err_second_next;
        drive      <= drive_next;
        signs      <= signs_next;
        count      <= count_next;
        done       <= done_next;
      end else if (point.ready) begin
        pvalid <= 1'b0;
      end
    end
  end

  assign point.valid       = pvalid;
  assign point.point_x     = OUT_BITS'(cur_x);
  assign point.point_y     = OUT_BITS'(cur_y);
  assign point.point_z     = OUT_BITS'(cur_z);
  assign point.point_count = count;
  assign point.last        = done;

endmodule

// ===== rtl/bl3_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bl3_setup: per-axis distance and direction of a new line
// Absolute difference and step direction of destination against source.
// ----------------------------------------------------------------------------
module bl3_setup #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0] src_x,
  input  logic [COORD_BITS-1:0] src_y,
  input  logic [COORD_BITS-1:0] src_z,
  input  logic [COORD_BITS-1:0] dst_x,
  input  logic [COORD_BITS-1:0] dst_y,
  input  logic [COORD_BITS-1:0] dst_z,
  output logic [COORD_BITS-1:0] delta_x,
  output logic [COORD_BITS-1:0] delta_y,
  output logic [COORD_BITS-1:0] delta_z,
  output logic [2:0]            signs
);

  always_comb begin
    signs[0] = dst_x > src_x;
    signs[1] = dst_y > src_y;
    signs[2] = dst_z > src_z;
    delta_x  = signs[0] ? dst_x - src_x : src_x - dst_x;
    delta_y  = signs[1] ? dst_y - src_y : src_y - dst_y;
    delta_z  = signs[2] ? dst_z - src_z : src_z - dst_z;
  end

endmodule

// ===== rtl/bl3_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bl3_checker: port-level checks of the 3D line generator
// Watches the point channel for stall behavior, reset, count progression and end repeats.
// ----------------------------------------------------------------------------
module bl3_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               valid,
  input logic                               ready,
  input logic [bl3_pkg::OUT_COORD_BITS-1:0] point_x,
  input logic [bl3_pkg::OUT_COORD_BITS-1:0] point_y,
  input logic [bl3_pkg::OUT_COORD_BITS-1:0] point_z,
  input logic [bl3_pkg::COUNT_BITS-1:0]     point_count,
  input logic                               last
);

  logic xfer;
  assign xfer = valid && ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(point_x) && $stable(point_y) &&
                           $stable(point_z) && $stable(point_count) && $stable(last)))
    else $error("point changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("point valid right after reset");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    (xfer && $past(xfer) && !$past(rst)) |->
      (point_count == 1 || point_count == $past(point_count) ||
       point_count == $past(point_count) + 1'b1))
    else $error("point count jumped");

  a_repeat_end: assert property (@(posedge clk) disable iff (rst)
    (xfer && $past(xfer) && !$past(rst) && $past(last) && point_count != 1) |->
      (last && point_x == $past(point_x) && point_y == $past(point_y) &&
       point_z == $past(point_z) && point_count == $past(point_count)))
    else $error("step after end did not repeat the final point");

endmodule

bind bresenham_line_3d bl3_checker u_bl3_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (point.valid),
  .ready       (point.ready),
  .point_x     (point.point_x),
  .point_y     (point.point_y),
  .point_z     (point.point_z),
  .point_count (point.point_count),
  .last        (point.last)
);

// ===== tb/tb_bresenham_line_3d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_3d: self-checking bench of the 3D line generator
// Feeds a table of directed starts and steps, then random lines with random
// gaps and output stalls. A local line tracer computes the expected point of
// every command transfer, unless a table row gives it; each point transfer is
// checked against the oldest expected point, field by field.
// ----------------------------------------------------------------------------
module tb_bresenham_line_3d;

  localparam int RANDOM_ITEMS = 1450;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_ROWS       = 26;

  typedef struct packed {
    logic        command;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [15:0] src_z;
    logic [15:0] dst_x;
    logic [15:0] dst_y;
    logic [15:0] dst_z;
  } line_cmd_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [16:0] count;
    logic        last;
  } line_point_t;

  typedef struct packed {
    line_cmd_t   c;
    logic        typed;
    line_point_t want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{16'h0, 16'h0, 16'h0, 17'd1, 1'b1}},
    '{'{bl3_pkg::CMD_START, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{16'h0, 16'h0, 16'h0, 17'd1, 1'b1}},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{16'h0, 16'h0, 16'h0, 17'd1, 1'b1}},
    '{'{bl3_pkg::CMD_START, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0}, 1'b1,
      '{16'hffff, 16'hffff, 16'hffff, 17'd1, 1'b0}},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'hffff, 16'hffff, 16'hffff,
        16'hffff, 16'hffff, 16'hffff}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0}, 1'b1,
      '{16'h0, 16'h0, 16'h0, 17'd1, 1'b0}},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'd5, 16'd5, 16'd5, 16'd8, 16'd5, 16'd5}, 1'b1,
      '{16'd5, 16'd5, 16'd5, 17'd1, 1'b0}},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'd10, 16'd10, 16'd10, 16'd13, 16'd13, 16'd10}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'd10, 16'd10, 16'd10, 16'd10, 16'd7, 16'd7}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'd100, 16'd200, 16'd300,
        16'd96, 16'd205, 16'd302}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_START, 16'haaaa, 16'h5555, 16'hffff,
        16'h5555, 16'haaaa, 16'h0}, 1'b0, '0},
    '{'{bl3_pkg::CMD_STEP, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 1'b0, '0}
  };

  logic clk;
  logic rst;

  bl3_cmd_if   cmd();
  bl3_point_if point();

  bresenham_line_3d #(.COORD_BITS(16)) uut (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .point (point)
  );

  // line tracer state, reset values as after a finished line at the origin
  logic [15:0] cur_pos [3] = '{16'h0, 16'h0, 16'h0};
  logic [15:0] axis_len [3] = '{16'h0, 16'h0, 16'h0};
  logic [15:0] end_major    = '0;
  logic [2:0]  climbs       = '0;
  bl3_pkg::axis_t major     = bl3_pkg::AXIS_X;
  int          err_first    = 0;
  int          err_second   = 0;
  logic [16:0] pts          = 17'd1;
  bit          finished     = 1'b1;

  line_point_t expected_points [$];
  line_point_t head;
  int          fail_count  = 0;
  int          idle_cycles = 0;
  bit          calm        = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic line_point_t trace_point(input line_cmd_t c);
    logic [15:0] from [3];
    logic [15:0] to [3];
    int          m1;
    int          m2;
    int          dd;
    line_point_t p;
    from = '{c.src_x, c.src_y, c.src_z};
    to   = '{c.dst_x, c.dst_y, c.dst_z};
    if (c.command == bl3_pkg::CMD_START) begin
      for (int a = 0; a < 3; a++) begin
        cur_pos[a]  = from[a];
        axis_len[a] = (to[a] > from[a]) ? to[a] - from[a] : from[a] - to[a];
        climbs[a]   = to[a] > from[a];
      end
      if (axis_len[0] >= axis_len[1] && axis_len[0] > axis_len[2]) begin
        major = bl3_pkg::AXIS_X;
      end else if (axis_len[1] >= axis_len[0] && axis_len[1] > axis_len[2]) begin
        major = bl3_pkg::AXIS_Y;
      end else begin
        major = bl3_pkg::AXIS_Z;
      end
      end_major = to[major];
    end
    m1 = (major == bl3_pkg::AXIS_X) ? 1 : 0;
    m2 = (major == bl3_pkg::AXIS_Z) ? 1 : 2;
    dd = int'(axis_len[major]);
    if (c.command == bl3_pkg::CMD_START) begin
      err_first  = 2 * int'(axis_len[m1]) - dd;
      err_second = 2 * int'(axis_len[m2]) - dd;
      pts        = 17'd1;
      finished   = (cur_pos[major] == end_major);
    end else if (!finished) begin
      cur_pos[major] = climbs[major] ? cur_pos[major] + 16'd1 : cur_pos[major] - 16'd1;
      if (err_first >= 0) begin
        cur_pos[m1] = climbs[m1] ? cur_pos[m1] + 16'd1 : cur_pos[m1] - 16'd1;
        err_first -= 2 * dd;
      end
      if (err_second >= 0) begin
        cur_pos[m2] = climbs[m2] ? cur_pos[m2] + 16'd1 : cur_pos[m2] - 16'd1;
        err_second -= 2 * dd;
      end
      err_first  += 2 * int'(axis_len[m1]);
      err_second += 2 * int'(axis_len[m2]);
      if (pts != '1) pts = pts + 17'd1;
      finished = (cur_pos[major] == end_major);
    end
    p.x     = cur_pos[0];
    p.y     = cur_pos[1];
    p.z     = cur_pos[2];
    p.count = pts;
    p.last  = finished;
    return p;
  endfunction

  function automatic int pause_cycles();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic line_cmd_t random_cmd(input logic command);
    line_cmd_t c;
    c.command = command;
    c.src_x   = 16'($urandom);
    c.src_y   = 16'($urandom);
    c.src_z   = 16'($urandom);
    c.dst_x   = 16'($urandom);
    c.dst_y   = 16'($urandom);
    c.dst_z   = 16'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input line_cmd_t c, input bit typed, input line_point_t want);
    int          gap;
    line_point_t traced;
    gap = pause_cycles();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd.valid   <= 1'b1;
    cmd.command <= c.command;
    cmd.src_x   <= c.src_x;
    cmd.src_y   <= c.src_y;
    cmd.src_z   <= c.src_z;
    cmd.dst_x   <= c.dst_x;
    cmd.dst_y   <= c.dst_y;
    cmd.dst_z   <= c.dst_z;
    do @(posedge clk); while (!cmd.ready);
    traced = trace_point(c);
    expected_points.push_back(typed ? want : traced);
  endtask

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  initial begin
    line_cmd_t c;
    int        s [3];
    int        e [3];
    int        d;
    int        span;
    int        nsteps;
    int        r;
    int        sent;
    rst         <= 1'b1;
    cmd.valid   <= 1'b0;
    cmd.command <= bl3_pkg::CMD_START;
    cmd.src_x   <= '0;
    cmd.src_y   <= '0;
    cmd.src_z   <= '0;
    cmd.dst_x   <= '0;
    cmd.dst_y   <= '0;
    cmd.dst_z   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++) begin
      send_cmd(DIR_ROWS[i].c, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r    = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (r < 80) begin
        // well-formed line, mostly short, usually stepped to its end and a little past
        c    = random_cmd(bl3_pkg::CMD_START);
        span = 0;
        for (int a = 0; a < 3; a++) begin
          s[a] = $urandom_range(0, 65535);
          if (r < 4) begin
            e[a] = $urandom_range(0, 65535);
          end else begin
            d = $urandom_range(0, 12);
            if ($urandom_range(0, 1)) e[a] = (s[a] + d <= 65535) ? s[a] + d : s[a] - d;
            else e[a] = (s[a] - d >= 0) ? s[a] - d : s[a] + d;
          end
          d = (e[a] > s[a]) ? e[a] - s[a] : s[a] - e[a];
          if (d > span) span = d;
        end
        c.src_x = 16'(s[0]);
        c.src_y = 16'(s[1]);
        c.src_z = 16'(s[2]);
        c.dst_x = 16'(e[0]);
        c.dst_y = 16'(e[1]);
        c.dst_z = 16'(e[2]);
        nsteps = span + $urandom_range(0, 2);
        if (nsteps > 40) nsteps = $urandom_range(1, 40);
        if ($urandom_range(0, 7) == 0) nsteps = $urandom_range(0, nsteps);
      end else if (r < 92) begin
        c      = random_cmd(bl3_pkg::CMD_START);
        nsteps = $urandom_range(0, 6);
      end else begin
        c      = random_cmd(1'($urandom));
        nsteps = 0;
      end
      send_cmd(c, 1'b0, '0);
      sent++;
      for (int k = 0; k < nsteps; k++) begin
        send_cmd(random_cmd(bl3_pkg::CMD_STEP), 1'b0, '0);
        sent++;
      end
    end

    cmd.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    point.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = pause_cycles();
      if (stall > 0) begin
        point.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      point.ready <= 1'b1;
      do @(posedge clk); while (!point.valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && point.valid && point.ready) begin
      if (expected_points.size() == 0) begin
        $display("%0t: point transfer with nothing expected, actual %0h %0h %0h %0h %0b",
                 $time, point.point_x, point.point_y, point.point_z,
                 point.point_count, point.last);
        fail_count++;
      end else begin
        head = expected_points.pop_front();
        check_field("point_x", 17'(head.x), 17'(point.point_x));
        check_field("point_y", 17'(head.y), 17'(point.point_y));
        check_field("point_z", 17'(head.z), 17'(point.point_z));
        check_field("point_count", head.count, point.point_count);
        check_field("last", 17'(head.last), 17'(point.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (point.valid && point.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
